FILE: hdl/swc_pkg.sv
// Package with the item types, register indexes and constants of the sprite window clipper.
package swc_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_WINDOW_LEFT   = 2'd0;
    localparam logic [1:0] CFG_WINDOW_TOP    = 2'd1;
    localparam logic [1:0] CFG_WINDOW_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_WINDOW_BOTTOM = 2'd3;

    localparam logic signed [15:0] WINDOW_LEFT_RESET   = 16'sd0;
    localparam logic signed [15:0] WINDOW_TOP_RESET    = 16'sd0;
    localparam logic signed [15:0] WINDOW_RIGHT_RESET  = 16'sd384;
    localparam logic signed [15:0] WINDOW_BOTTOM_RESET = 16'sd224;

    // Base subtracted from the table address; it is a multiple of the 2^17 span
    // that the table word is taken from, so only the low bits below it matter.
    localparam logic [17:0] TABLE_BASE = 18'h20000;
    localparam logic [15:0] TABLE_MASK = 16'hFFF0;

    typedef struct packed {
        logic [4:0]         slot_index;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] parallax;
        logic [13:0]        half_width;
        logic [13:0]        half_height;
        logic signed [15:0] source_x;
        logic signed [15:0] source_y;
        logic signed [15:0] source_parallax;
        logic [17:0]        table_address;
        logic [15:0]        mode_bits;
        logic [3:0]         map_segment;
    } swc_sprite_t;

    typedef struct packed {
        logic               rendered;
        logic [4:0]         slot_out;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic signed [15:0] screen_parallax;
        logic signed [15:0] map_x;
        logic signed [15:0] map_y;
        logic signed [15:0] map_parallax;
        logic signed [15:0] width_field;
        logic signed [15:0] height_field;
        logic [15:0]        head_word;
        logic [15:0]        table_word;
    } swc_attr_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } swc_window_t;

endpackage

FILE: hdl/swc_sprite_if.sv
// Valid/ready channel interfaces for sprite descriptors and world attributes.
interface swc_sprite_if import swc_pkg::*; ();
    logic        valid;
    logic        ready;
    swc_sprite_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swc_attr_if import swc_pkg::*; ();
    logic      valid;
    logic      ready;
    swc_attr_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/swc_clip.sv
// Combinational clipping of one sprite against the camera window.
module swc_clip import swc_pkg::*;
#(
    parameter int SIZE_DISPLACEMENT = 1
)
(
    input  swc_sprite_t sprite,
    input  swc_window_t window,
    output swc_attr_t   attr
);

    localparam logic signed [15:0] SizeDisp = 16'(SIZE_DISPLACEMENT);

    function automatic logic signed [17:0] sx18(input logic signed [15:0] v);
        return {{2{v[15]}}, v};
    endfunction

    logic signed [15:0] gx0;
    logic signed [15:0] gy0;
    logic signed [15:0] aux;
    logic signed [15:0] w0;
    logic signed [15:0] h0;
    logic signed [17:0] lim;
    logic signed [17:0] dl;
    logic               no_table;
    logic               left_clip;
    logic               top_clip;
    logic signed [15:0] gx1;
    logic signed [15:0] w1;
    logic signed [15:0] mx1;
    logic signed [15:0] gy1;
    logic signed [15:0] h1;
    logic signed [15:0] my1;
    logic signed [15:0] md;
    logic signed [15:0] w2;
    logic signed [15:0] h2;
    logic               ok;
    logic [16:0]        tsum;

    always_comb
    begin
        gx0 = sprite.center_x - $signed({2'b00, sprite.half_width});
        gy0 = sprite.center_y - $signed({2'b00, sprite.half_height});
        aux = sprite.parallax[15] ? 16'(-sprite.parallax) : sprite.parallax;
        w0  = $signed({1'b0, sprite.half_width, 1'b0});
        h0  = $signed({1'b0, sprite.half_height, 1'b0});
        no_table = (sprite.table_address == '0);

        // Left edge, widened by the parallax; skipped when a parameter table is used.
        lim       = sx18(window.left) - sx18(aux);
        dl        = lim - sx18(gx0);
        left_clip = (lim > sx18(gx0)) && no_table;
        gx1 = left_clip ? lim[15:0] : gx0;
        w1  = left_clip ? w0 - dl[15:0] : w0;
        mx1 = left_clip ? sprite.source_x + dl[15:0] : sprite.source_x;

        // Top edge; the clipped amount also moves the source and the table word.
        top_clip = window.top > gy0;
        md  = top_clip ? 16'(window.top - gy0) : 16'sd0;
        gy1 = top_clip ? window.top : gy0;
        h1  = h0 - md;
        my1 = sprite.source_y + md;

        // Right edge, widened by the parallax.
        if (sx18(w1) + sx18(gx1) >= sx18(window.right) + sx18(aux))
            w2 = window.right - gx1 + aux;
        else
            w2 = w1;

        // Bottom edge.
        if (sx18(h1) + sx18(gy1) >= sx18(window.bottom))
            h2 = window.bottom - gy1;
        else
            h2 = h1;

        ok = (w2 > SizeDisp) && (h2 > SizeDisp);

        // Only bits 16..5 of the table sum reach the word, so 17 bits suffice.
        tsum = sprite.table_address[16:0] + {md[12:0], 4'b0000} - TABLE_BASE[16:0];

        attr = '0;
        attr.slot_out = sprite.slot_index;
        if (ok)
        begin
            attr.rendered        = 1'b1;
            attr.screen_x        = gx1;
            attr.screen_y        = gy1;
            attr.screen_parallax = sprite.parallax;
            attr.map_x           = mx1;
            attr.map_y           = my1;
            attr.map_parallax    = sprite.source_parallax;
            attr.width_field     = w2 - SizeDisp;
            attr.height_field    = h2 - SizeDisp;
            attr.head_word       = sprite.mode_bits | {12'h000, sprite.map_segment};
            attr.table_word      = no_table ? 16'h0000 : ({tsum[16:5], 4'h0} & TABLE_MASK);
        end
    end

endmodule

FILE: hdl/sprite_window_clipper.sv
// Top level of the sprite window clipper: window registers and a two-register pipeline.
//
// Each sprite descriptor transferred on the sprite channel yields exactly one
// world attribute item on the attr channel, in order. The block takes one
// sprite per cycle while the attr channel accepts items: a descriptor is
// captured in an input register, clipped by one pass of adds and compares
// against the four window registers, and the result is held in an output
// register; a stalled output only blocks new input once both registers are
// full. Window registers are written through the configuration port and
// should change only while no sprite is in flight.
module sprite_window_clipper import swc_pkg::*;
#(
    parameter int SIZE_DISPLACEMENT = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    swc_sprite_if.sink        sprite,
    swc_attr_if.source        attr,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    swc_window_t window_reg;
    swc_window_t window_next;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    swc_sprite_t s1_item_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    swc_attr_t   res_reg;
    swc_attr_t   clip_result;
    logic        s1_ready;
    logic        res_ready;

    swc_clip #(
        .SIZE_DISPLACEMENT(SIZE_DISPLACEMENT)
    ) u_clip (
        .sprite(s1_item_reg),
        .window(window_reg),
        .attr  (clip_result)
    );

    always_comb
    begin
        window_next = window_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LEFT:   window_next.left   = cfg_data;
                CFG_WINDOW_TOP:    window_next.top    = cfg_data;
                CFG_WINDOW_RIGHT:  window_next.right  = cfg_data;
                CFG_WINDOW_BOTTOM: window_next.bottom = cfg_data;
                default:           window_next = window_reg;
            endcase
        end
    end

    // The output register frees up when its item transfers; the input register
    // frees up when its item moves into the output register.
    assign res_ready = !res_valid_reg || attr.ready;
    assign s1_ready  = !s1_valid_reg || res_ready;

    assign sprite.ready = s1_ready;
    assign attr.valid   = res_valid_reg;
    assign attr.data    = res_reg;

    always_comb
    begin
        s1_valid_next  = s1_ready ? sprite.valid : s1_valid_reg;
        res_valid_next = res_ready ? s1_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg.left   <= WINDOW_LEFT_RESET;
            window_reg.top    <= WINDOW_TOP_RESET;
            window_reg.right  <= WINDOW_RIGHT_RESET;
            window_reg.bottom <= WINDOW_BOTTOM_RESET;
            s1_valid_reg      <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && sprite.valid)
            s1_item_reg <= sprite.data;
        if (res_ready && s1_valid_reg)
            res_reg <= clip_result;
    end

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the sprite window clipper: directed, window sweep and random sprites.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swc_pkg::*;

    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 6;
    localparam int SIZE_DISPLACEMENT = 1;
    localparam int PIPE_LATENCY      = 2;
    localparam int WATCHDOG_LIMIT    = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    swc_sprite_if sprite_ch ();
    swc_attr_if   attr_ch ();

    sprite_window_clipper #(
        .SIZE_DISPLACEMENT(SIZE_DISPLACEMENT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sprite   (sprite_ch),
        .attr     (attr_ch),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    swc_window_t win;
    swc_attr_t   pending_attrs[$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          ready_hold     = 0;
    bit          sender_idle    = 1'b1;
    bit          sink_idle      = 1'b1;

    function automatic int to_s16(int v);
        logic signed [15:0] t;
        t = v[15:0];
        return t;
    endfunction

    // Clips one sprite against the window and packs the attributes it should produce.
    function automatic swc_attr_t clip_sprite(swc_sprite_t s, swc_window_t wnd);
        swc_attr_t   a;
        int          cx, cy, par, hw, hh, sx, sy;
        int          wl, wt, wr, wb;
        int          x0, y0, apar, wid, hgt, lim, d, dy;
        logic [31:0] tword;
        a = '0;
        a.slot_out = s.slot_index;
        cx  = $signed(s.center_x);
        cy  = $signed(s.center_y);
        par = $signed(s.parallax);
        sx  = $signed(s.source_x);
        sy  = $signed(s.source_y);
        hw  = int'(s.half_width);
        hh  = int'(s.half_height);
        wl  = $signed(wnd.left);
        wt  = $signed(wnd.top);
        wr  = $signed(wnd.right);
        wb  = $signed(wnd.bottom);

        x0   = to_s16(cx - hw);
        y0   = to_s16(cy - hh);
        apar = to_s16(par < 0 ? -par : par);
        wid  = to_s16(hw * 2);
        hgt  = to_s16(hh * 2);
        dy   = 0;

        // A sprite with a parameter table is never clipped on the left.
        lim = wl - apar;
        if (lim > x0 && s.table_address == '0) begin
            d   = lim - x0;
            sx  = sx + d;
            wid = to_s16(wid - d);
            x0  = to_s16(lim);
        end
        if (wt > y0) begin
            d   = wt - y0;
            dy  = to_s16(d);
            sy  = sy + dy;
            hgt = to_s16(hgt - d);
            y0  = wt;
        end
        if (wid + x0 >= wr + apar)
            wid = to_s16(wr - x0 + apar);
        if (SIZE_DISPLACEMENT >= wid)
            return a;
        if (hgt + y0 >= wb)
            hgt = to_s16(wb - y0);
        if (SIZE_DISPLACEMENT >= hgt)
            return a;

        a.rendered        = 1'b1;
        a.screen_x        = x0[15:0];
        a.screen_y        = y0[15:0];
        a.screen_parallax = s.parallax;
        a.map_x           = sx[15:0];
        a.map_y           = sy[15:0];
        a.map_parallax    = s.source_parallax;
        a.width_field     = 16'(wid - SIZE_DISPLACEMENT);
        a.height_field    = 16'(hgt - SIZE_DISPLACEMENT);
        a.head_word       = s.mode_bits | {12'b0, s.map_segment};
        if (s.table_address != '0) begin
            tword = 32'(s.table_address) + (32'(dy) << 4) - 32'(TABLE_BASE);
            a.table_word = tword[16:1] & TABLE_MASK;
        end
        return a;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Records the expectation of every accepted sprite and checks every attribute transfer.
    always @(posedge clk) begin : attr_monitor
        swc_attr_t exp_attr;
        swc_attr_t act_attr;
        if (rst_n) begin
            if (sprite_ch.valid && sprite_ch.ready)
                pending_attrs.push_back(clip_sprite(sprite_ch.data, win));
            if (attr_ch.valid && attr_ch.ready) begin
                act_attr = attr_ch.data;
                if (pending_attrs.size() == 0) begin
                    $error("attribute transfer for slot %0d with no sprite pending",
                           act_attr.slot_out);
                    mismatch_count++;
                end
                else begin
                    exp_attr = pending_attrs.pop_front();
                    check_field("rendered", 16'(exp_attr.rendered), 16'(act_attr.rendered));
                    check_field("slot_out", 16'(exp_attr.slot_out), 16'(act_attr.slot_out));
                    check_field("screen_x", exp_attr.screen_x, act_attr.screen_x);
                    check_field("screen_y", exp_attr.screen_y, act_attr.screen_y);
                    check_field("screen_parallax", exp_attr.screen_parallax,
                                act_attr.screen_parallax);
                    check_field("map_x", exp_attr.map_x, act_attr.map_x);
                    check_field("map_y", exp_attr.map_y, act_attr.map_y);
                    check_field("map_parallax", exp_attr.map_parallax,
                                act_attr.map_parallax);
                    check_field("width_field", exp_attr.width_field, act_attr.width_field);
                    check_field("height_field", exp_attr.height_field,
                                act_attr.height_field);
                    check_field("head_word", exp_attr.head_word, act_attr.head_word);
                    check_field("table_word", exp_attr.table_word, act_attr.table_word);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((sprite_ch.valid && sprite_ch.ready) || (attr_ch.valid && attr_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Back-pressure on the attr channel when sink_idle is set: mostly short stalls, a few long ones.
    always @(negedge clk) begin : attr_stall
        int r;
        if (ready_hold > 0)
            ready_hold--;
        else if (!sink_idle)
            attr_ch.ready <= 1'b1;
        else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                attr_ch.ready <= 1'b1;
                ready_hold = $urandom_range(0, 6);
            end
            else begin
                attr_ch.ready <= 1'b0;
                ready_hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(3, 25);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (!sender_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Valid stays high so that a following sprite can go back to back.
    task automatic send_sprite(input swc_sprite_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            sprite_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sprite_ch.valid <= 1'b1;
        sprite_ch.data  <= s;
        do
            @(posedge clk);
        while (!sprite_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain_attrs();
        sprite_ch.valid <= 1'b0;
        while (pending_attrs.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic set_window(input int left, input int top, input int right, input int bottom);
        logic [1:0]  idx  [4];
        logic [15:0] vals [4];
        idx  = '{CFG_WINDOW_LEFT, CFG_WINDOW_TOP, CFG_WINDOW_RIGHT, CFG_WINDOW_BOTTOM};
        vals = '{16'(left), 16'(top), 16'(right), 16'(bottom)};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        win.left   = vals[0];
        win.top    = vals[1];
        win.right  = vals[2];
        win.bottom = vals[3];
        @(negedge clk);
    endtask

    function automatic logic [15:0] near_edge(int a, int b);
        int base;
        case ($urandom_range(0, 2))
            0:       base = a;
            1:       base = b;
            default: base = (a + b) / 2;
        endcase
        return 16'(base + int'($urandom_range(0, 600)) - 300);
    endfunction

    function automatic logic [13:0] pick_half();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 14'($urandom_range(0, 2));
        if (r < 20)
            return 14'($urandom);
        if (r < 23)
            return 14'h3FFF;
        return 14'($urandom_range(0, 300));
    endfunction

    // Mostly sprites placed around the window edges; the rest is raw noise.
    function automatic swc_sprite_t rand_sprite();
        swc_sprite_t  s;
        logic [191:0] raw;
        int           r;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        s = raw[$bits(swc_sprite_t)-1:0];
        if ($urandom_range(0, 99) < 80) begin
            s.center_x    = near_edge($signed(win.left), $signed(win.right));
            s.center_y    = near_edge($signed(win.top), $signed(win.bottom));
            s.half_width  = pick_half();
            s.half_height = pick_half();
            r = $urandom_range(0, 99);
            if (r < 50)
                s.parallax = 16'(int'($urandom_range(0, 32)) - 16);
            else if (r < 55)
                s.parallax = 16'h8000;
            else if (r < 60)
                s.parallax = 16'h7FFF;
            else if (r < 80)
                s.parallax = '0;
            r = $urandom_range(0, 99);
            if (r < 50)
                s.table_address = '0;
            else if (r < 80)
                s.table_address = TABLE_BASE + 18'($urandom_range(0, 4095));
        end
        return s;
    endfunction

    function automatic swc_sprite_t sprite_of(input logic [4:0] slot, input int cx, input int cy,
                                              input int par, input int hw, input int hh,
                                              input logic [17:0] tab);
        swc_sprite_t s;
        s = rand_sprite();
        s.slot_index    = slot;
        s.center_x      = 16'(cx);
        s.center_y      = 16'(cy);
        s.parallax      = 16'(par);
        s.half_width    = 14'(hw);
        s.half_height   = 14'(hh);
        s.table_address = tab;
        return s;
    endfunction

    // Runs against the reset window.
    task automatic test_directed();
        swc_sprite_t list[$];
        swc_sprite_t s;
        list.push_back(sprite_of(0, 192, 112, 0, 32, 32, 0));
        list.push_back(sprite_of(1, 10, 100, 0, 32, 16, 0));          // left clip
        list.push_back(sprite_of(2, 10, 100, 0, 32, 16, 18'h20000));  // table blocks left clip
        list.push_back(sprite_of(3, 100, 5, 0, 16, 32, 18'h20010));   // top clip moves table
        list.push_back(sprite_of(4, 380, 100, 0, 32, 16, 0));         // right clip
        list.push_back(sprite_of(5, 100, 220, 0, 16, 32, 0));         // bottom clip
        list.push_back(sprite_of(6, 100, 100, 0, 0, 20, 0));          // zero width
        list.push_back(sprite_of(7, 100, 100, 0, 20, 0, 0));          // zero height
        list.push_back(sprite_of(8, 100, 100, 0, 1, 1, 0));           // smallest drawn
        list.push_back(sprite_of(9, 393, 100, 0, 10, 10, 0));         // right clip leaves one
        list.push_back(sprite_of(10, 100, 233, 0, 10, 10, 0));        // bottom clip leaves one
        list.push_back(sprite_of(11, 100, 100, -32768, 20, 20, 0));   // parallax abs wraps
        list.push_back(sprite_of(12, -30, 100, 50, 40, 20, 0));
        list.push_back(sprite_of(13, 420, 100, -50, 40, 20, 0));
        list.push_back(sprite_of(14, 0, 0, 0, 16383, 16383, 0));
        list.push_back(sprite_of(15, 0, 0, 0, 16383, 16383, 18'h3FFFF));
        list.push_back(sprite_of(16, -32768, -32768, 0, 100, 100, 0));
        list.push_back(sprite_of(17, 32767, 32767, 32767, 100, 100, 1));
        list.push_back(sprite_of(18, 50, -100, 0, 200, 200, 1));
        list.push_back(sprite_of(19, -1000, 100, 0, 10, 10, 0));      // far off the left
        s = sprite_of(31, 100, 100, 0, 20, 20, 0);
        s.mode_bits   = '1;
        s.map_segment = '1;
        list.push_back(s);
        list.push_back('0);
        list.push_back('1);
        foreach (list[i])
            send_sprite(list[i]);
        drain_attrs();
    endtask

    task automatic test_window_extremes();
        int wins [6][4];
        wins = '{'{-32768, -32768, 32767, 32767},
                 '{32767, 32767, -32768, -32768},
                 '{0, 0, 0, 0},
                 '{-100, -50, 100, 50},
                 '{32467, 32567, 32767, 32767},
                 '{-32768, -32768, -32468, -32568}};
        for (int w = 0; w < 6; w++) begin
            set_window(wins[w][0], wins[w][1], wins[w][2], wins[w][3]);
            sender_idle = (w % 2 == 0);
            sink_idle   = (w % 3 != 2);
            repeat (40) send_sprite(rand_sprite());
            drain_attrs();
        end
    endtask

    task automatic test_random_windows();
        int l, t;
        for (int p = 0; p < 10; p++) begin
            if ($urandom_range(0, 3) == 0)
                set_window(int'(16'($urandom)), int'(16'($urandom)),
                           int'(16'($urandom)), int'(16'($urandom)));
            else begin
                l = int'($urandom_range(0, 400)) - 200;
                t = int'($urandom_range(0, 400)) - 200;
                set_window(l, t, l + int'($urandom_range(0, 500)),
                           t + int'($urandom_range(0, 300)));
            end
            sender_idle = (p % 4 != 1);
            sink_idle   = (p % 4 != 2);
            repeat (100) send_sprite(rand_sprite());
            drain_attrs();
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_WINDOW_LEFT;
        cfg_data        = '0;
        sprite_ch.valid = 1'b0;
        sprite_ch.data  = '0;
        attr_ch.ready   = 1'b0;
        win = '{left: WINDOW_LEFT_RESET, top: WINDOW_TOP_RESET,
                right: WINDOW_RIGHT_RESET, bottom: WINDOW_BOTTOM_RESET};
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_window_extremes();
        test_random_windows();

        drain_attrs();
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        if (mismatch_count == 0 && pending_attrs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sprite_window_clipper.f
hdl/swc_pkg.sv
hdl/swc_sprite_if.sv
hdl/swc_clip.sv
hdl/sprite_window_clipper.sv
sim/tb_top.sv
